@@ src/stable_priority_insert_queue_top_defines.svh @@
// assertion macros shared by the stable priority insert queue rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef STABLE_PRIORITY_INSERT_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_INSERT_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPIQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SPIQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/spiq_pkg.sv @@
// shared types, codes and constants of the stable priority insert queue
// no dependencies; imported by the front, the back and the top level
package spiq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 32;

   localparam int ID_W   = 16;
   localparam int PRIO_W = 3;
   localparam int STAT_W = 3;
   localparam int POS_W  = 7;

   // priority range
   localparam logic [PRIO_W-1:0] PRIO_MIN   = 3'd1;
   localparam logic [PRIO_W-1:0] PRIO_MAX   = 3'd5;
   localparam int                PRIO_COUNT = 5;

   // command field
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LIST   = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] ST_BADPRIO  = 3'd2;
   localparam logic [STAT_W-1:0] ST_LISTED   = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

   // command kinds decided by the front
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BAD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

   // command queue between front and back (power of two)
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   record_id;
   } cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [ID_W-1:0]   record_id;
      logic [PRIO_W-1:0] prio;
      logic              last;
   } rsp_type;

endpackage

@@ src/spiq_front.sv @@
// front of the queue: takes request words, classifies them, holds them in a
// short command queue for the back; depends on spiq_pkg
module spiq_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [spiq_pkg::PRIO_W-1:0] req_prio,
   input  logic [spiq_pkg::ID_W-1:0]   req_record_id,
   output logic                    cmd_valid,
   input  logic                    cmd_pop,
   output spiq_pkg::cmd_type       cmd_out
);
   import spiq_pkg::*;

   cmd_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  push;
   cmd_type               cmd_new;

   assign req_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd_out   = fifo_ff[rd_ptr_ff];

   // classify: list, bad priority or insert
   always_comb begin
      cmd_new.prio      = req_prio;
      cmd_new.record_id = req_record_id;
      if (req_cmd == CMD_LIST) begin
         cmd_new.kind = KIND_LIST;
      end else if (req_prio < PRIO_MIN || req_prio > PRIO_MAX) begin
         cmd_new.kind = KIND_BAD;
      end else begin
         cmd_new.kind = KIND_INSERT;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = FIFO_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (cmd_pop) begin
         rd_ptr_in = FIFO_PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !cmd_pop) begin
         count_in = FIFO_CNT_W'(count_ff + 1'b1);
      end else if (!push && cmd_pop) begin
         count_in = FIFO_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

@@ src/spiq_back.sv @@
// back of the queue: sorted row of slot cells, per-priority counts, list
// sequencer and the result register; depends on spiq_pkg and the defines header
`include "stable_priority_insert_queue_top_defines.svh"

module spiq_back #(
   parameter int QUEUE_DEPTH = spiq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  spiq_pkg::cmd_type cmd_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spiq_pkg::rsp_type rsp_out
);
   import spiq_pkg::*;

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic [ID_W-1:0]   slot_id_ff   [QUEUE_DEPTH];
   logic [ID_W-1:0]   slot_id_in   [QUEUE_DEPTH];
   logic [PRIO_W-1:0] slot_prio_ff [QUEUE_DEPTH];
   logic [PRIO_W-1:0] slot_prio_in [QUEUE_DEPTH];
   logic [ID_W-1:0]   up_id   [QUEUE_DEPTH];
   logic [PRIO_W-1:0] up_prio [QUEUE_DEPTH];
   logic [ID_W-1:0]   dn_id   [QUEUE_DEPTH];
   logic [PRIO_W-1:0] dn_prio [QUEUE_DEPTH];

   logic [OCC_W-1:0] prio_cnt_ff [PRIO_COUNT];
   logic [OCC_W-1:0] prio_cnt_in [PRIO_COUNT];
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [OCC_W-1:0] list_cnt_ff, list_cnt_in;
   logic             state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             do_insert;
   logic             do_rotate;
   logic             list_last;
   logic [OCC_W-1:0] place;
   logic [OCC_W-1:0] prio_total;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid && out_free;
   assign do_insert = cmd_pop && (cmd_in.kind == KIND_INSERT)
                      && (occ_ff != OCC_W'(QUEUE_DEPTH));
   assign do_rotate = (state_ff == ST_LIST) && out_free;
   assign list_last = (OCC_W'(list_cnt_ff + 1'b1) == occ_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

   // place of a new entry: count of entries at equal or more urgent priority
   always_comb begin
      place      = '0;
      prio_total = '0;
      for (int k = 0; k < PRIO_COUNT; k++) begin
         if (PRIO_W'(k + 1) <= cmd_in.prio) begin
            place = OCC_W'(place + prio_cnt_ff[k]);
         end
         prio_total = OCC_W'(prio_total + prio_cnt_ff[k]);
      end
   end

   // neighbor taps, edge cells tied to themselves
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_tap
      if (i == 0) begin : g_first
         assign up_id[i]   = slot_id_ff[i];
         assign up_prio[i] = slot_prio_ff[i];
      end else begin : g_up
         assign up_id[i]   = slot_id_ff[i-1];
         assign up_prio[i] = slot_prio_ff[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_final
         assign dn_id[i]   = slot_id_ff[i];
         assign dn_prio[i] = slot_prio_ff[i];
      end else begin : g_dn
         assign dn_id[i]   = slot_id_ff[i+1];
         assign dn_prio[i] = slot_prio_ff[i+1];
      end
   end

   // each cell: take the new entry, shift down on insert, rotate up on list
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      always_comb begin
         slot_id_in[i]   = slot_id_ff[i];
         slot_prio_in[i] = slot_prio_ff[i];
         if (do_insert) begin
            if (OCC_W'(i) == place) begin
               slot_id_in[i]   = cmd_in.record_id;
               slot_prio_in[i] = cmd_in.prio;
            end else if (OCC_W'(i) > place && OCC_W'(i) <= occ_ff) begin
               slot_id_in[i]   = up_id[i];
               slot_prio_in[i] = up_prio[i];
            end
         end else if (do_rotate) begin
            if (OCC_W'(i + 1) == occ_ff) begin
               slot_id_in[i]   = slot_id_ff[0];
               slot_prio_in[i] = slot_prio_ff[0];
            end else if (OCC_W'(i + 1) < occ_ff) begin
               slot_id_in[i]   = dn_id[i];
               slot_prio_in[i] = dn_prio[i];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < PRIO_COUNT; k++) begin
         prio_cnt_in[k] = prio_cnt_ff[k];
         if (do_insert && cmd_in.prio == PRIO_W'(k + 1)) begin
            prio_cnt_in[k] = OCC_W'(prio_cnt_ff[k] + 1'b1);
         end
      end
   end

   // sequencer and result register
   always_comb begin
      state_in     = state_ff;
      list_cnt_in  = list_cnt_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (cmd_pop) begin
         rsp_in       = '0;
         rsp_in.last  = 1'b1;
         rsp_valid_in = 1'b1;
         unique case (cmd_in.kind)
            KIND_BAD: begin
               rsp_in.status = ST_BADPRIO;
            end
            KIND_INSERT: begin
               if (occ_ff == OCC_W'(QUEUE_DEPTH)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.status   = ST_INSERTED;
                  rsp_in.position = POS_W'(POS_W'(place) + 1'b1);
                  occ_in          = OCC_W'(occ_ff + 1'b1);
               end
            end
            KIND_LIST: begin
               if (occ_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_LIST;
                  list_cnt_in  = '0;
               end
            end
            default: begin
               rsp_in.status = ST_BADPRIO;
            end
         endcase
      end else if (do_rotate) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = ST_LISTED;
         rsp_in.position  = POS_W'(POS_W'(list_cnt_ff) + 1'b1);
         rsp_in.record_id = slot_id_ff[0];
         rsp_in.prio      = slot_prio_ff[0];
         rsp_in.last      = list_last;
         if (list_last) begin
            state_in = ST_IDLE;
         end else begin
            list_cnt_in = OCC_W'(list_cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         list_cnt_ff  <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < PRIO_COUNT; k++) begin
            prio_cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         list_cnt_ff  <= list_cnt_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < PRIO_COUNT; k++) begin
            prio_cnt_ff[k] <= prio_cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_id_ff[i]   <= slot_id_in[i];
         slot_prio_ff[i] <= slot_prio_in[i];
      end
   end

   `SPIQ_ASSERT_IMPL(a_counts_match, clock, reset, 1'b1, prio_total == occ_ff, "count mismatch")
   `SPIQ_ASSERT_IMPL(a_list_index, clock, reset, state_ff == ST_LIST, list_cnt_ff < occ_ff, "list index")
   `SPIQ_ASSERT_NEXT(a_insert_grows, clock, reset, do_insert, occ_ff == OCC_W'($past(occ_ff) + 1'b1), "insert lost")
   `SPIQ_ASSERT_NEXT(a_list_keeps, clock, reset, state_ff == ST_LIST, $stable(occ_ff), "list changed size")

endmodule

@@ src/stable_priority_insert_queue_top.sv @@
// top level of the stable priority insert queue: stream ports, word packing
// depends on spiq_pkg, spiq_front and spiq_back
//
//   channel   dir   tdata (low bit up)                         tuser    tlast
//   req_      in    priority_req[2:0], record_id[18:3]         cmd      -
//   rsp_      out   position[6:0], out_record_id[22:7],        status   last
//                   out_priority[25:23]
//
// an insert, a dropped insert or a list of an empty queue gives one word; a
// list of n entries gives n words, one word a cycle while rsp_ does not
// stall, as the slot row rotates past its head cell
// reset is synchronous and active high; it clears occupancy, counts and
// handshake state, the slot row itself is not cleared
// a two-word command queue parts the front from the back, and a result
// register parts the back from the rsp_ side, so either side may stall
module stable_priority_insert_queue_top #(
   parameter int QUEUE_DEPTH = spiq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // priority_req, record_id, zero fill
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // position, out_record_id, out_priority, zero fill
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);
   import spiq_pkg::*;

   // command queue to the back
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp;

   spiq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_cmd       (req_tuser),
      .req_prio      (req_tdata[2:0]),
      .req_record_id (req_tdata[18:3]),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop),
      .cmd_out       (cmd)
   );

   // sorted slot row and list sequencer
   spiq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_in    (cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_out   (rsp)
   );

   // result word packing
   assign rsp_tdata = {6'd0, rsp.prio, rsp.record_id, rsp.position};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule

@@ sim/stable_priority_insert_queue_top_tb.sv @@
// self-checking bench for the stable priority insert queue top level
// depends on spiq_pkg and stable_priority_insert_queue_top; keeps its own sorted copy
`timescale 1ns / 1ps

module stable_priority_insert_queue_top_tb;
   import spiq_pkg::*;

   localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam int ID_MAX      = (1 << ID_W) - 1;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // priority_req, record_id, zero fill
   logic        req_tuser  = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // position, out_record_id, out_priority, zero fill
   logic [2:0]  rsp_tuser;         // status
   logic        rsp_tlast;

   stable_priority_insert_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // sorted shadow of the queue contents, most urgent first
   logic [ID_W-1:0]   shadow_ids[QUEUE_DEPTH];
   logic [PRIO_W-1:0] shadow_prios[QUEUE_DEPTH];
   int                shadow_count = 0;

   // result words still owed by the block, oldest first
   rsp_type due_words[$];

   // idle chances in percent, per cycle
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int fail_count    = 0;
   int words_checked = 0;
   int kept_count    = 0;
   int dropped_count = 0;
   int list_count    = 0;
   int sent_count    = 0;

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #3_000_000;
      $display("stable_priority_insert_queue_top_tb NOT OK");
      $finish;
   end

   function automatic void owe_word(logic [STAT_W-1:0] status, int position,
                                    logic [ID_W-1:0] record_id,
                                    logic [PRIO_W-1:0] prio, bit last);
      rsp_type w;
      w.status    = status;
      w.position  = position[POS_W-1:0];
      w.record_id = record_id;
      w.prio      = prio;
      w.last      = last;
      due_words.push_back(w);
   endfunction

   // apply one accepted command to the shadow and queue up its words
   function automatic void apply_command(logic cmd, logic [PRIO_W-1:0] prio,
                                         logic [ID_W-1:0] record_id);
      int place;
      if (cmd == CMD_LIST) begin
         list_count++;
         if (shadow_count == 0) begin
            owe_word(ST_EMPTY, 0, '0, '0, 1'b1);
         end else begin
            for (int i = 0; i < shadow_count; i++)
               owe_word(ST_LISTED, i + 1, shadow_ids[i], shadow_prios[i],
                        i == shadow_count - 1);
         end
      end else if (prio < PRIO_MIN || prio > PRIO_MAX) begin
         // priority check wins over the full check
         dropped_count++;
         owe_word(ST_BADPRIO, 0, '0, '0, 1'b1);
      end else if (shadow_count >= QUEUE_DEPTH) begin
         dropped_count++;
         owe_word(ST_FULL, 0, '0, '0, 1'b1);
      end else begin
         // new entry goes behind every entry of equal or more urgent priority
         place = 0;
         while (place < shadow_count && shadow_prios[place] <= prio)
            place++;
         for (int i = shadow_count; i > place; i--) begin
            shadow_ids[i]   = shadow_ids[i-1];
            shadow_prios[i] = shadow_prios[i-1];
         end
         shadow_ids[place]   = record_id;
         shadow_prios[place] = prio;
         shadow_count++;
         kept_count++;
         owe_word(ST_INSERTED, place + 1, '0, '0, 1'b1);
      end
   endfunction

   // present one word on req_, with a random gap first, and log it on acceptance
   task automatic send_word(logic cmd, logic [PRIO_W-1:0] prio,
                            logic [ID_W-1:0] record_id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, record_id, prio};
      do
         @(posedge clock);
      while (!req_tready);
      apply_command(cmd, prio, record_id);
      sent_count++;
   endtask

   // hold the sender off until every owed word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (due_words.size() != 0)
         @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic void check_field(string name, int expv, int actv);
      if (expv != actv) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
         fail_count++;
      end
   endfunction

   // compare every accepted rsp_ word with the oldest owed one
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, got status %0h tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            w = due_words.pop_front();
            words_checked++;
            check_field("status",        w.status,    rsp_tuser);
            check_field("position",      w.position,  rsp_tdata[6:0]);
            check_field("out_record_id", w.record_id, rsp_tdata[22:7]);
            check_field("out_priority",  w.prio,      rsp_tdata[25:23]);
            check_field("zero fill",     0,           rsp_tdata[31:26]);
            check_field("last",          w.last,      rsp_tlast);
         end
      end
   end

   // fixed cases: empty list, bad priorities, extremes, ties, a full list
   task automatic test_directed();
      send_idle_pct = 10;
      recv_idle_pct = 30;
      send_word(CMD_LIST,   3'd0,     16'h0000);
      send_word(CMD_INSERT, 3'd0,     16'h0001);
      send_word(CMD_INSERT, 3'd6,     16'h0002);
      send_word(CMD_INSERT, 3'd7,     16'hffff);
      send_word(CMD_INSERT, 3'd3,     16'h0000);
      send_word(CMD_INSERT, PRIO_MAX, 16'hffff);
      send_word(CMD_INSERT, PRIO_MIN, 16'h1234);
      // ties keep arrival order
      send_word(CMD_INSERT, 3'd3,     16'haaaa);
      send_word(CMD_INSERT, 3'd3,     16'h5555);
      send_word(CMD_INSERT, PRIO_MAX, 16'h8001);
      send_word(CMD_INSERT, 3'd2,     16'h7ffe);
      send_word(CMD_INSERT, 3'd4,     16'h0f0f);
      send_word(CMD_INSERT, PRIO_MIN, 16'hfffe);
      // list ignores its priority and id fields
      send_word(CMD_LIST,   3'd7,     16'hffff);
   endtask

   // fill the queue, pause until drained, then hit the full and bad-on-full cases
   task automatic test_full_queue();
      send_idle_pct = 20;
      recv_idle_pct = 20;
      while (shadow_count < QUEUE_DEPTH)
         send_word(CMD_INSERT, PRIO_W'($urandom_range(PRIO_MAX, PRIO_MIN)),
                   ID_W'($urandom_range(ID_MAX)));
      wait_drained();
      send_word(CMD_INSERT, PRIO_MIN, 16'hbeef);
      send_word(CMD_INSERT, 3'd0,     16'hbeef);
      send_word(CMD_INSERT, 3'd7,     16'h4321);
      send_word(CMD_LIST,   3'd0,     16'h0000);
      wait_drained();
   endtask

   // random mix: mostly inserts with any priority code, some lists
   task automatic test_random(int count, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 18)
            send_word(CMD_LIST, PRIO_W'($urandom_range(7)),
                      ID_W'($urandom_range(ID_MAX)));
         else
            send_word(CMD_INSERT, PRIO_W'($urandom_range(7)),
                      ID_W'($urandom_range(ID_MAX)));
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(104, 20, 47);
      test_full_queue();
      test_random(103, 47, 20);
      test_random(103, 0, 0);

      // any stray word from a longest list would land in this window
      wait_drained();
      repeat (QUEUE_DEPTH + 8) @(posedge clock);

      $display("ran %0d commands: %0d inserts kept, %0d dropped, %0d lists",
               sent_count, kept_count, dropped_count, list_count);
      $display("%0d result words checked, final queue fill %0d of %0d",
               words_checked, shadow_count, QUEUE_DEPTH);
      if (fail_count == 0)
         $display("stable_priority_insert_queue_top_tb OK");
      else
         $display("stable_priority_insert_queue_top_tb NOT OK");
      $finish;
   end

endmodule
